FILE: src/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg: shared definitions for the bounded ordered list engine
// Opcodes, cell commands and the structs passed between the controller and
// the row of storage cells.
// ----------------------------------------------------------------------------
package bole_pkg;

  // Width of one stored value and of the count field on the result channel.
  localparam int DATA_W      = 32;
  localparam int OUT_COUNT_W = 5;

  // Operation codes carried by an input transaction.
  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_INSERT = 3'd2;
  localparam logic [2:0] OP_GET    = 3'd3;
  localparam logic [2:0] OP_ERASE  = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  // Commands broadcast to every cell of the row.
  localparam logic [1:0] CELL_HOLD = 2'd0; // keep contents
  localparam logic [1:0] CELL_LOAD = 2'd1; // cell at walk index takes operand
  localparam logic [1:0] CELL_SHL  = 2'd2; // cells at or past walk take right neighbor
  localparam logic [1:0] CELL_INS  = 2'd3; // open a gap at walk index and fill it

  typedef struct packed {
    logic [1:0]        op;
    logic [DATA_W-1:0] operand;
  } cell_cmd_t;

  typedef struct packed {
    logic valid;    // cell lies below the entry count
    logic le;       // stored value <= operand (signed)
    logic eq;       // stored value == operand
    logic at_walk;  // cell sits at the broadcast walk index
  } cell_stat_t;

endpackage

FILE: src/bole_cell.sv
// ----------------------------------------------------------------------------
// bole_cell: one storage cell of the ordered list
// Holds one entry, compares it against the broadcast operand and moves data
// to or from its neighbors as the broadcast command says.
// ----------------------------------------------------------------------------
module bole_cell #(
  parameter int IW  = 4,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic                         clk,
  input  bole_pkg::cell_cmd_t          cmd,
  input  logic [IW-1:0]                walk,
  input  logic [CW-1:0]                cnt,
  input  logic [bole_pkg::DATA_W-1:0]  left_val,
  input  logic [bole_pkg::DATA_W-1:0]  right_val,
  output logic [bole_pkg::DATA_W-1:0]  val,
  output bole_pkg::cell_stat_t         stat
);
  import bole_pkg::*;

  logic [DATA_W-1:0] val_r;
  logic [DATA_W-1:0] val_nxt;
  logic              at_walk;
  logic              past_walk;

  assign at_walk   = (walk == IW'(IDX));
  assign past_walk = (IW'(IDX) > walk);

  // Local compares reported to the controller.
  assign stat.valid   = (CW'(IDX) < cnt);
  assign stat.le      = ($signed(val_r) <= $signed(cmd.operand));
  assign stat.eq      = (val_r == cmd.operand);
  assign stat.at_walk = at_walk;
  assign val          = val_r;

  // Next contents from the broadcast command and the neighbors.
  always_comb begin
    val_nxt = val_r;
    case (cmd.op)
      CELL_HOLD: val_nxt = val_r;
      CELL_LOAD: begin
        if (at_walk) val_nxt = cmd.operand;
      end
      CELL_SHL: begin
        if (at_walk || past_walk) val_nxt = right_val;
      end
      CELL_INS: begin
        if (at_walk) val_nxt = cmd.operand;
        else if (past_walk) val_nxt = left_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

FILE: src/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine: bounded list of signed values in a cell chain
// Push, pop, get and clear finish without a walk; sorted insert and erase walk
// a token index along the row of cells, one cell per cycle, except that erase
// holds the index while it removes a matching entry.
// Results: push, pop, get, clear and rejected inserts give their result in the
// cycle after the input transaction; insert and erase give theirs once the
// walk ends and the output register is free.
// A new transaction is accepted only after the previous one has finished.
// Reset: rst_n (synchronous, active low) empties the list and the output
// register; cell contents are not cleared and need no clearing pass.
module bounded_ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // opcode[2:0], operand_value[34:3], position[42:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // ok[0], result_value[32:1], count[37:33]
);
  import bole_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CNT_CAP = CW'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_INS  = 2'd1;
  localparam logic [1:0] ST_ERA  = 2'd2;

  logic [1:0]             st_r, st_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [DATA_W-1:0]      opnd_r, opnd_nxt;
  logic                   found_r, found_nxt;
  logic                   out_tvalid_r;
  logic                   out_ok_r;
  logic [DATA_W-1:0]      out_val_r;
  logic [OUT_COUNT_W-1:0] out_cnt_r;

  logic [2:0]             in_opcode;
  logic [DATA_W-1:0]      in_operand;
  logic [7:0]             in_pos;
  logic                   accept;
  logic                   out_free;
  logic                   emit;
  logic                   res_ok;
  logic [DATA_W-1:0]      res_val;
  cell_cmd_t              cmd;
  logic [IW-1:0]          walk;
  logic [DATA_W-1:0]      cell_val [CAPACITY];
  cell_stat_t             cell_stat [CAPACITY];
  logic [CAPACITY-1:0]    le_hit;
  logic [CAPACITY-1:0]    eq_hit;
  logic                   ins_hit;
  logic                   era_hit;
  logic                   get_ok;
  logic [DATA_W-1:0]      get_val;

  // Unpack the input transaction.
  assign in_opcode  = in_tdata[2:0];
  assign in_operand = in_tdata[34:3];
  assign in_pos     = in_tdata[42:35];

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;

  // Row of storage cells; each cell sees its two neighbors.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_v;
    logic [DATA_W-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_val[i+1];
    end

    bole_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .walk      (walk),
      .cnt       (cnt_r),
      .left_val  (left_v),
      .right_val (right_v),
      .val       (cell_val[i]),
      .stat      (cell_stat[i])
    );

    assign le_hit[i] = cell_stat[i].at_walk && cell_stat[i].valid && cell_stat[i].le;
    assign eq_hit[i] = cell_stat[i].at_walk && cell_stat[i].valid && cell_stat[i].eq;
  end

  assign ins_hit = (k_r >= cnt_r) || (|le_hit);
  assign era_hit = |eq_hit;

  // Read port for get: select the cell at the requested position.
  assign get_ok = ({1'b0, in_pos} < 9'(cnt_r));
  always_comb begin
    get_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ({1'b0, in_pos} == 9'(i)) get_val = get_val | cell_val[i];
    end
  end

  // Controller: decode, walk sequencing and cell command broadcast.
  always_comb begin
    st_nxt      = st_r;
    k_nxt       = k_r;
    cnt_nxt     = cnt_r;
    opnd_nxt    = opnd_r;
    found_nxt   = found_r;
    emit        = 1'b0;
    res_ok      = 1'b0;
    res_val     = '0;
    cmd.op      = CELL_HOLD;
    cmd.operand = opnd_r;
    walk        = k_r[IW-1:0];
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.operand = in_operand;
          opnd_nxt    = in_operand;
          case (in_opcode)
            OP_PUSH: begin
              emit = 1'b1;
              if (!in_operand[DATA_W-1] && (cnt_r < CNT_CAP)) begin
                cmd.op  = CELL_LOAD;
                walk    = cnt_r[IW-1:0];
                cnt_nxt = cnt_r + 1'b1;
                res_ok  = 1'b1;
              end
            end
            OP_POP: begin
              emit = 1'b1;
              if (cnt_r != '0) begin
                cmd.op  = CELL_SHL;
                walk    = '0;
                cnt_nxt = cnt_r - 1'b1;
                res_ok  = 1'b1;
                res_val = cell_val[0];
              end else begin
                res_val = '1;
              end
            end
            OP_INSERT: begin
              if (cnt_r < CNT_CAP) begin
                st_nxt = ST_INS;
                k_nxt  = '0;
              end else begin
                emit = 1'b1;
              end
            end
            OP_GET: begin
              emit = 1'b1;
              if (get_ok) begin
                res_ok  = 1'b1;
                res_val = get_val;
              end else begin
                res_val = '1;
              end
            end
            OP_ERASE: begin
              st_nxt    = ST_ERA;
              k_nxt     = '0;
              found_nxt = 1'b0;
            end
            OP_CLEAR: begin
              emit    = 1'b1;
              cnt_nxt = '0;
              res_ok  = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_INS: begin
        // Stop at the first entry <= operand, or at the tail.
        if (ins_hit) begin
          if (out_free) begin
            cmd.op  = CELL_INS;
            cnt_nxt = cnt_r + 1'b1;
            res_ok  = 1'b1;
            emit    = 1'b1;
            st_nxt  = ST_IDLE;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      ST_ERA: begin
        // Either remove the matching entry in place or step past it.
        if (k_r >= cnt_r) begin
          if (out_free) begin
            res_ok = found_r;
            emit   = 1'b1;
            st_nxt = ST_IDLE;
          end
        end else if (era_hit) begin
          cmd.op    = CELL_SHL;
          cnt_nxt   = cnt_r - 1'b1;
          found_nxt = 1'b1;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      k_r          <= '0;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      k_r     <= k_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    opnd_r <= opnd_nxt;
    if (emit) begin
      out_ok_r  <= res_ok;
      out_val_r <= res_val;
      out_cnt_r <= OUT_COUNT_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_val_r, out_ok_r};

`ifndef SYNTHESIS
  // The entry count never exceeds the number of cells.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_CAP)
    else $error("entry count exceeds capacity");

  // A walk in progress blocks new input transactions.
  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_IDLE) |-> !in_tready)
    else $error("input accepted during a walk");

  // Clear gives an immediate successful result with an empty list.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_CLEAR)) |=>
      (out_tvalid_r && out_ok_r && (out_cnt_r == '0) && (cnt_r == '0)))
    else $error("clear did not empty the list");

  // A successful pop removes exactly one entry.
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_POP) && (cnt_r != '0)) |=>
      (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pop did not decrement the count");
`endif

endmodule
